// ===== rtl/euclid_gcd_macros.svh =====
// Assertion helpers for the GCD block.
`ifndef EUCLID_GCD_MACROS_SVH
`define EUCLID_GCD_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EGCD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("egcd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define EGCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("egcd: next-cycle check failed");

`endif

// ===== rtl/egcd_pkg.sv =====
`default_nettype none

package egcd_pkg;

    localparam int OPERAND_BITS = 31;
    // k never exceeds OPERAND_BITS-1 (shared factors of two in a nonzero operand)
    localparam int SHIFT_BITS   = $clog2(OPERAND_BITS);

    typedef struct packed {
        logic load;     // take new operands
        logic step;     // one binary GCD reduction
        logic capture;  // move result into the output register
    } egcd_cmd_t;

    typedef struct packed {
        logic done;     // one operand has reached zero
    } egcd_status_t;

endpackage

`default_nettype wire

// ===== rtl/egcd_datapath.sv =====
`default_nettype none

module egcd_datapath
    import egcd_pkg::*;
(
    input  wire logic                    aclk,
    input  wire egcd_cmd_t               cmd,
    input  wire logic [OPERAND_BITS-1:0] first_value,
    input  wire logic [OPERAND_BITS-1:0] second_value,
    output egcd_status_t                 status,
    output logic [OPERAND_BITS-1:0]      divisor
);

    logic [OPERAND_BITS-1:0] a_reg, a_next;
    logic [OPERAND_BITS-1:0] b_reg, b_next;
    logic [SHIFT_BITS-1:0]   k_reg, k_next;
    logic [OPERAND_BITS-1:0] result_reg, result_next;
    logic [OPERAND_BITS-1:0] a_minus_b;
    logic [OPERAND_BITS-1:0] b_minus_a;
    logic                    a_ge_b;

    assign a_minus_b = a_reg - b_reg;
    assign b_minus_a = b_reg - a_reg;
    assign a_ge_b    = (a_reg >= b_reg);

    assign status.done = (a_reg == '0) || (b_reg == '0);

    always_comb begin
        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        result_next = result_reg;
        if (cmd.load) begin
            a_next = first_value;
            b_next = second_value;
            k_next = '0;
        end else if (cmd.step) begin
            if (!a_reg[0] && !b_reg[0]) begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end else if (!a_reg[0]) begin
                a_next = a_reg >> 1;
            end else if (!b_reg[0]) begin
                b_next = b_reg >> 1;
            end else if (a_ge_b) begin
                // odd minus odd is even, so halve straight away
                a_next = a_minus_b >> 1;
            end else begin
                b_next = b_minus_a >> 1;
            end
        end
        if (cmd.capture) begin
            // one operand is zero here, so the OR is the other one
            result_next = (a_reg | b_reg) << k_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        result_reg <= result_next;
    end

    assign divisor = result_reg;

endmodule

`default_nettype wire

// ===== rtl/egcd_ctrl.sv =====
`default_nettype none

module egcd_ctrl
    import egcd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire egcd_status_t status,
    output egcd_cmd_t         cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (status.done) begin
                    // wait for the output slot to free up
                    if (!m_valid_reg || m_ready) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        m_valid_next = m_valid_reg;
        if (cmd.capture) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/euclid_gcd.sv =====
// Greatest common divisor of two unsigned OPERAND_BITS-wide operands.
// Input channel: s_valid/s_ready with s_first_value and s_second_value;
// a transaction starts one computation. Output channel: m_valid/m_ready
// with m_divisor, exactly one transaction per input transaction, in order.
// gcd(a,0) = a, so both operands zero give zero.
// The datapath runs binary GCD: each cycle halves an even operand (both
// when both are even) or replaces the larger odd one by half the
// difference. Every step drops at least one bit from the operand pair, so
// a computation takes at most 2*OPERAND_BITS steps (62 here) between the
// load and the capture of the result, much less for typical operands. One
// item is worked on at a time; the next input is taken as soon as the
// result sits in the output register.
// If the receiver stalls, the result waits in that register, the block
// still accepts and finishes the next item, then holds it until the
// register frees. Reset (aresetn, synchronous, active low) drops any
// computation in flight and any pending result.
`default_nettype none

`include "euclid_gcd_macros.svh"

module euclid_gcd
    import egcd_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [OPERAND_BITS-1:0] s_first_value,
    input  wire logic [OPERAND_BITS-1:0] s_second_value,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [OPERAND_BITS-1:0]      m_divisor
);

    egcd_cmd_t    cmd;
    egcd_status_t status;

    egcd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    egcd_datapath u_datapath (
        .aclk         (aclk),
        .cmd          (cmd),
        .first_value  (s_first_value),
        .second_value (s_second_value),
        .status       (status),
        .divisor      (m_divisor)
    );

    `EGCD_ASSERT_NOW(a_capture_when_done, aclk, aresetn, cmd.capture, status.done)
    `EGCD_ASSERT_NOW(a_no_step_and_capture, aclk, aresetn, cmd.step, !cmd.capture && !cmd.load)
    `EGCD_ASSERT_NEXT(a_busy_after_load, aclk, aresetn, cmd.load, !s_ready)
    `EGCD_ASSERT_NEXT(a_valid_after_capture, aclk, aresetn, cmd.capture, m_valid && s_ready)

endmodule

`default_nettype wire

// ===== dv/euclid_gcd_test.sv =====
`timescale 1ns / 100ps

module euclid_gcd_test;
    import egcd_pkg::*;

    typedef logic [OPERAND_BITS-1:0] operand_t;

    localparam operand_t OPERAND_MAX  = {OPERAND_BITS{1'b1}};
    localparam int       RANDOM_ITEMS = 900;
    localparam int       STEP_LIMIT   = 2 * OPERAND_BITS + 4;
    localparam int       DRAIN_CYCLES = 2 * OPERAND_BITS + 8;
    localparam int       HOLD_CYCLES  = 300;

    typedef struct {
        operand_t first;
        operand_t second;
        bit       known;
        operand_t expected;
    } gcd_case_t;

    typedef struct {
        bit       known;
        operand_t value;
    } typed_divisor_t;

    localparam int DIRECTED_COUNT = 20;

    // known = 1: expected divisor typed in; otherwise taken from the predictor
    gcd_case_t directed_cases [DIRECTED_COUNT] = '{
        '{operand_t'(0), operand_t'(0), 1'b1, operand_t'(0)},
        '{OPERAND_MAX, operand_t'(0), 1'b1, OPERAND_MAX},
        '{operand_t'(0), OPERAND_MAX, 1'b1, OPERAND_MAX},
        '{OPERAND_MAX, OPERAND_MAX, 1'b1, OPERAND_MAX},
        '{operand_t'(1), OPERAND_MAX, 1'b1, operand_t'(1)},
        '{OPERAND_MAX, operand_t'(1), 1'b1, operand_t'(1)},
        '{OPERAND_MAX, OPERAND_MAX - 1, 1'b1, operand_t'(1)},
        '{operand_t'(0), operand_t'(1), 1'b1, operand_t'(1)},
        '{operand_t'(1), operand_t'(0), 1'b1, operand_t'(1)},
        '{operand_t'(12345), operand_t'(0), 1'b1, operand_t'(12345)},
        '{operand_t'(0), operand_t'(9876), 1'b1, operand_t'(9876)},
        '{operand_t'(1) << 30, operand_t'(1) << 30, 1'b1, operand_t'(1) << 30},
        '{operand_t'(1) << 30, operand_t'(1) << 29, 1'b1, operand_t'(1) << 29},
        '{operand_t'(48), operand_t'(18), 1'b0, operand_t'(0)},
        '{operand_t'(18), operand_t'(48), 1'b0, operand_t'(0)},
        '{operand_t'(1836311903), operand_t'(1134903170), 1'b0, operand_t'(0)},
        '{operand_t'(1134903170), operand_t'(1836311903), 1'b0, operand_t'(0)},
        '{operand_t'(1) << 30, operand_t'(3) << 20, 1'b0, operand_t'(0)},
        '{operand_t'(31'h5555_5555), operand_t'(31'h2AAA_AAAA), 1'b0, operand_t'(0)},
        '{OPERAND_MAX, operand_t'(1) << 30, 1'b0, operand_t'(0)}
    };

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    operand_t s_first_value;
    operand_t s_second_value;
    logic     m_valid;
    logic     m_ready;
    operand_t m_divisor;

    operand_t       divisor_expected [$];
    typed_divisor_t typed_pending [$];
    int             mismatches;
    int             results_taken;

    euclid_gcd u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_value  (s_first_value),
        .s_second_value (s_second_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_divisor      (m_divisor)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic operand_t gcd_of(operand_t x, operand_t y);
        operand_t r;
        for (int n = 0; n < STEP_LIMIT && y != 0; n++) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    task automatic report_mismatch(input string what, input operand_t got,
                                   input operand_t want);
        $display("ERROR %0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Starts and ends at a falling edge.
    task automatic offer_operands(input operand_t a, input operand_t b, input bit known,
                                  input operand_t want, input bit may_idle);
        typed_divisor_t row;
        if (may_idle && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        row.known = known;
        row.value = want;
        typed_pending.push_back(row);
        s_valid        <= 1'b1;
        s_first_value  <= a;
        s_second_value <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Receiver: random back-pressure, one long hold-off, one calm window.
    initial begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held && results_taken >= 150) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready   <= 1'b0;
            end else if (results_taken >= 400 && results_taken < 600) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // Scoreboard: predict on input transaction, compare on output transaction.
    always @(posedge aclk) begin
        typed_divisor_t row;
        operand_t       want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                row = typed_pending.pop_front();
                want = row.known ? row.value : gcd_of(s_first_value, s_second_value);
                divisor_expected.push_back(want);
            end
            if (m_valid && m_ready) begin
                results_taken++;
                if (divisor_expected.size() == 0) begin
                    report_mismatch("result with nothing outstanding", m_divisor, '0);
                end else begin
                    want = divisor_expected.pop_front();
                    if (m_divisor !== want)
                        report_mismatch("divisor", m_divisor, want);
                end
            end
        end
    end

    initial begin
        #4ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        operand_t a;
        operand_t b;
        operand_t g;
        operand_t fa;
        operand_t fb;
        operand_t t;
        int       shape;
        int       k;

        mismatches     = 0;
        results_taken  = 0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_first_value  = '0;
        s_second_value = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_cases[i])
            offer_operands(directed_cases[i].first, directed_cases[i].second,
                           directed_cases[i].known, directed_cases[i].expected, 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            shape = $urandom_range(0, 9);
            case (shape)
                0, 1, 2, 3: begin
                    a = operand_t'($urandom());
                    b = operand_t'($urandom());
                end
                4: begin
                    // shared factor so the divisor is not trivially one
                    g = operand_t'($urandom_range(1, 1 << 16));
                    a = operand_t'($urandom_range(0, OPERAND_MAX / g)) * g;
                    b = operand_t'($urandom_range(0, OPERAND_MAX / g)) * g;
                end
                5: begin
                    a = ($urandom_range(0, 2) == 0) ? '0 : operand_t'($urandom());
                    b = (a != 0 && $urandom_range(0, 1) == 0) ? operand_t'($urandom()) : '0;
                    if ($urandom_range(0, 1) == 1) begin
                        t = a;
                        a = b;
                        b = t;
                    end
                end
                6: begin
                    a = operand_t'($urandom_range(1, 1 << 20));
                    b = a * operand_t'($urandom_range(1, 1 << 10));
                    if ($urandom_range(0, 1) == 1) begin
                        t = a;
                        a = b;
                        b = t;
                    end
                end
                7: begin
                    a = operand_t'($urandom_range(0, 255));
                    b = operand_t'($urandom_range(0, 255));
                end
                8: begin
                    k = $urandom_range(0, OPERAND_BITS - 1);
                    a = operand_t'(1) << k;
                    b = (operand_t'(1) << $urandom_range(0, OPERAND_BITS - 1))
                        * operand_t'($urandom_range(1, 7));
                end
                default: begin
                    // consecutive Fibonacci numbers: Euclid's longest chains
                    fa = 1;
                    fb = 1;
                    repeat ($urandom_range(1, 44)) begin
                        t  = fa + fb;
                        fa = fb;
                        fb = t;
                    end
                    a = fb;
                    b = fa;
                    if ($urandom_range(0, 1) == 1) begin
                        a = fa;
                        b = fb;
                    end
                end
            endcase
            offer_operands(a, b, 1'b0, '0, !(i >= 300 && i < 500));
        end
        s_valid <= 1'b0;

        while (divisor_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
